// File: rtl/digit_prefix_trie_lookup_core_assert.svh
// Assertion macros for the digit prefix trie lookup core.
// Used by modules that carry concurrent checks; needs clk and rst_n in scope.
`ifndef DIGIT_PREFIX_TRIE_LOOKUP_CORE_ASSERT_SVH
`define DIGIT_PREFIX_TRIE_LOOKUP_CORE_ASSERT_SVH
`ifndef SYNTHESIS
`define DPTL_ASSERT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);
`define DPTL_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);
`else
`define DPTL_ASSERT(lbl, ante, cons, msg)
`define DPTL_ASSERT_NXT(lbl, ante, cons, msg)
`endif
`endif

// File: rtl/dptl_pkg.sv
// Shared constants, codes and types of the digit prefix trie lookup core.
// No dependencies.
`timescale 1ns / 1ps

package dptl_pkg;

    localparam int NODE_FANOUT    = 16;
    localparam int MAX_DEPTH      = 32;
    localparam int NODE_COUNT     = 1024;
    localparam int DOMAIN_ID_BITS = 16;

    localparam int IDX_W     = (NODE_FANOUT > 1) ? $clog2(NODE_FANOUT) : 1;
    localparam int NODE_W    = (NODE_COUNT > 1) ? $clog2(NODE_COUNT) : 1;
    localparam int FREE_W    = $clog2(NODE_COUNT + 1);
    localparam int ADDR_W    = NODE_W + IDX_W;
    localparam int RAM_DEPTH = 1 << ADDR_W;
    localparam int DOM_W     = DOMAIN_ID_BITS;
    localparam int SLOT_W    = NODE_W + 1 + DOM_W;
    localparam int POS_W     = $clog2(MAX_DEPTH + 1);

    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    localparam int ALPHA_SIZE = 16;
    localparam int CNT_W      = 5;

    localparam logic [63:0]      CHAR_LOW_RST  = 64'h3837_3635_3433_3231;
    localparam logic [63:0]      CHAR_HIGH_RST = 64'h0000_0000_002A_3039;
    localparam logic [CNT_W-1:0] CHAR_CNT_RST  = CNT_W'(11);

    localparam logic [1:0] CFG_CHAR_LOW  = 2'd0;
    localparam logic [1:0] CFG_CHAR_HIGH = 2'd1;
    localparam logic [1:0] CFG_CHAR_CNT  = 2'd2;

    localparam logic OP_LOOKUP = 1'b0;
    localparam logic OP_INSERT = 1'b1;

    localparam logic [2:0] ERR_NONE      = 3'd0;
    localparam logic [2:0] STAT_INSERTED = 3'd0;
    localparam logic [2:0] STAT_MATCH    = 3'd1;
    localparam logic [2:0] STAT_NOMATCH  = 3'd2;
    localparam logic [2:0] STAT_INVALID  = 3'd3;
    localparam logic [2:0] STAT_TOOLONG  = 3'd4;
    localparam logic [2:0] STAT_BOUND    = 3'd5;
    localparam logic [2:0] STAT_FULL     = 3'd6;

    typedef struct packed {
        logic             op;
        logic             last;
        logic             too_long;
        logic             invalid;
        logic [IDX_W-1:0] idx;
        logic [DOM_W-1:0] dom;
    } item_t;

endpackage

// File: rtl/dptl_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module dptl_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// File: rtl/dptl_front.sv
// Front end: alphabet registers, symbol-to-slot mapping and request classification.
// Depends on dptl_pkg.
`timescale 1ns / 1ps

module dptl_front (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [1:0]          cfg_index,
    input  logic [63:0]         cfg_data,
    input  logic                sym_valid,
    output logic                sym_stall,
    input  logic                operation,
    input  logic [7:0]          symbol,
    input  logic                last_symbol,
    input  logic [5:0]          prefix_length,
    input  logic [15:0]         domain_id,
    input  logic                q_full,
    input  logic                clearing,
    output logic                q_push,
    output dptl_pkg::item_t     q_item
);

    logic [63:0]                    low_reg;
    logic [63:0]                    high_reg;
    logic [dptl_pkg::CNT_W-1:0]     cnt_reg;
    logic [dptl_pkg::ALPHA_SIZE*8-1:0] alpha;
    logic [dptl_pkg::CNT_W-1:0]     n_chars;
    logic                           hit;
    logic [dptl_pkg::IDX_W-1:0]     idx;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            low_reg  <= dptl_pkg::CHAR_LOW_RST;
            high_reg <= dptl_pkg::CHAR_HIGH_RST;
            cnt_reg  <= dptl_pkg::CHAR_CNT_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                dptl_pkg::CFG_CHAR_LOW:  low_reg  <= cfg_data;
                dptl_pkg::CFG_CHAR_HIGH: high_reg <= cfg_data;
                dptl_pkg::CFG_CHAR_CNT:  cnt_reg  <= cfg_data[dptl_pkg::CNT_W-1:0];
                default: ;
            endcase
        end
    end

    assign alpha   = {high_reg, low_reg};
    assign n_chars = (cnt_reg > dptl_pkg::CNT_W'(dptl_pkg::ALPHA_SIZE)) ?
                     dptl_pkg::CNT_W'(dptl_pkg::ALPHA_SIZE) : cnt_reg;

    // lowest matching position wins
    always_comb
    begin
        hit = 1'b0;
        idx = '0;
        for (int i = dptl_pkg::ALPHA_SIZE - 1; i >= 0; i--)
        begin
            if ((dptl_pkg::CNT_W'(i) < n_chars) && (alpha[8*i +: 8] == symbol))
            begin
                hit = 1'b1;
                idx = dptl_pkg::IDX_W'(i % dptl_pkg::NODE_FANOUT);
            end
        end
    end

    assign sym_stall = q_full || clearing;
    assign q_push    = sym_valid && !sym_stall;

    always_comb
    begin
        q_item.op       = operation;
        q_item.last     = last_symbol;
        q_item.too_long = (prefix_length >= 6'(dptl_pkg::MAX_DEPTH));
        q_item.invalid  = !hit;
        q_item.idx      = idx;
        q_item.dom      = dptl_pkg::DOM_W'(domain_id);
    end

endmodule

// File: rtl/dptl_queue.sv
// Short request queue between the front end and the trie walk engine.
// Depends on dptl_pkg.
`timescale 1ns / 1ps

module dptl_queue (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    input  dptl_pkg::item_t push_item,
    output logic            full,
    input  logic            pop,
    output logic            q_valid,
    output dptl_pkg::item_t q_item
);

    dptl_pkg::item_t                 entry_reg [dptl_pkg::QUEUE_DEPTH];
    logic [dptl_pkg::QPTR_W-1:0]     wptr_reg;
    logic [dptl_pkg::QPTR_W-1:0]     rptr_reg;
    logic [dptl_pkg::QCNT_W-1:0]     count_reg;
    logic [dptl_pkg::QPTR_W-1:0]     wptr_next;
    logic [dptl_pkg::QPTR_W-1:0]     rptr_next;
    logic [dptl_pkg::QCNT_W-1:0]     count_next;

    assign full    = (count_reg == dptl_pkg::QCNT_W'(dptl_pkg::QUEUE_DEPTH));
    assign q_valid = (count_reg != '0);
    assign q_item  = entry_reg[rptr_reg];

    always_comb
    begin
        wptr_next  = wptr_reg;
        rptr_next  = rptr_reg;
        count_next = count_reg;
        if (push)
        begin
            wptr_next = (wptr_reg == dptl_pkg::QPTR_W'(dptl_pkg::QUEUE_DEPTH - 1)) ?
                        '0 : wptr_reg + 1'b1;
        end
        if (pop)
        begin
            rptr_next = (rptr_reg == dptl_pkg::QPTR_W'(dptl_pkg::QUEUE_DEPTH - 1)) ?
                        '0 : rptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg  <= '0;
            rptr_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            wptr_reg  <= wptr_next;
            rptr_reg  <= rptr_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wptr_reg] <= push_item;
        end
    end

endmodule

// File: rtl/dptl_back.sv
// Trie walk engine: node store clear pass, insert and lookup walks, result register.
// Depends on dptl_pkg, dptl_ram and digit_prefix_trie_lookup_core_assert.svh.
`timescale 1ns / 1ps
`include "digit_prefix_trie_lookup_core_assert.svh"

module dptl_back (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            q_valid,
    input  dptl_pkg::item_t q_item,
    output logic            q_pop,
    output logic            clearing,
    output logic            res_valid,
    input  logic            res_stall,
    output logic [2:0]      status,
    output logic [15:0]     found_domain,
    output logic [5:0]      match_length
);

    typedef struct packed {
        logic [dptl_pkg::NODE_W-1:0] child;
        logic                        bound;
        logic [dptl_pkg::DOM_W-1:0]  dom;
    } slot_t;

    localparam logic [1:0] ST_CLEAR = 2'd0;
    localparam logic [1:0] ST_IDLE  = 2'd1;
    localparam logic [1:0] ST_EXEC  = 2'd2;

    logic [1:0]                   state_reg, state_next;
    logic [dptl_pkg::ADDR_W-1:0]  clr_reg, clr_next;
    logic [dptl_pkg::NODE_W-1:0]  cur_reg, cur_next;
    logic [dptl_pkg::POS_W-1:0]   pos_reg, pos_next;
    logic [dptl_pkg::DOM_W-1:0]   bdom_reg, bdom_next;
    logic [dptl_pkg::POS_W-1:0]   blen_reg, blen_next;
    logic                         ended_reg, ended_next;
    logic [2:0]                   err_reg, err_next;
    logic [dptl_pkg::FREE_W-1:0]  free_reg, free_next;
    dptl_pkg::item_t              hold_reg, hold_next;
    logic                         res_valid_reg, res_valid_next;
    logic [2:0]                   status_reg;
    logic [dptl_pkg::DOM_W-1:0]   fdom_reg;
    logic [dptl_pkg::POS_W-1:0]   mlen_reg;

    logic                         res_free;
    logic                         res_load;
    logic                         done_op;
    logic [2:0]                   res_status;
    logic [dptl_pkg::DOM_W-1:0]   res_dom;
    logic [dptl_pkg::POS_W-1:0]   res_len;

    logic                         ram_we;
    logic [dptl_pkg::ADDR_W-1:0]  ram_waddr;
    slot_t                        ram_wdata;
    logic [dptl_pkg::ADDR_W-1:0]  ram_raddr;
    slot_t                        ram_rdata;

    dptl_ram #(
        .WIDTH (dptl_pkg::SLOT_W),
        .DEPTH (dptl_pkg::RAM_DEPTH)
    ) u_node_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign res_free  = !res_valid_reg || !res_stall;
    assign clearing  = (state_reg == ST_CLEAR);
    assign ram_raddr = {cur_reg, q_item.idx};

    always_comb
    begin
        state_next = state_reg;
        clr_next   = clr_reg;
        cur_next   = cur_reg;
        pos_next   = pos_reg;
        bdom_next  = bdom_reg;
        blen_next  = blen_reg;
        ended_next = ended_reg;
        err_next   = err_reg;
        free_next  = free_reg;
        hold_next  = hold_reg;
        ram_we     = 1'b0;
        ram_waddr  = {cur_reg, hold_reg.idx};
        ram_wdata  = ram_rdata;
        q_pop      = 1'b0;
        res_load   = 1'b0;
        done_op    = hold_reg.op;

        unique case (state_reg)
            ST_CLEAR:
            begin
                ram_we    = 1'b1;
                ram_waddr = clr_reg;
                ram_wdata = '0;
                clr_next  = clr_reg + 1'b1;
                if (clr_reg == '1)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (q_valid && (!q_item.last || res_free))
                begin
                    q_pop     = 1'b1;
                    hold_next = q_item;
                    done_op   = q_item.op;
                    res_load  = q_item.last;
                    if (err_reg != dptl_pkg::ERR_NONE)
                    begin
                        err_next = err_reg;
                    end
                    else if (q_item.op == dptl_pkg::OP_INSERT)
                    begin
                        if (q_item.too_long ||
                            (pos_reg >= dptl_pkg::POS_W'(dptl_pkg::MAX_DEPTH - 1)))
                        begin
                            err_next = dptl_pkg::STAT_TOOLONG;
                        end
                        else if (q_item.invalid)
                        begin
                            err_next = dptl_pkg::STAT_INVALID;
                        end
                        else
                        begin
                            res_load   = 1'b0;
                            state_next = ST_EXEC;
                        end
                    end
                    else if (!ended_reg)
                    begin
                        if (pos_reg >= dptl_pkg::POS_W'(dptl_pkg::MAX_DEPTH))
                        begin
                            ended_next = 1'b1;
                        end
                        else if (q_item.invalid)
                        begin
                            err_next = dptl_pkg::STAT_INVALID;
                        end
                        else
                        begin
                            res_load   = 1'b0;
                            state_next = ST_EXEC;
                        end
                    end
                end
            end
            ST_EXEC:
            begin
                state_next = ST_IDLE;
                res_load   = hold_reg.last;
                if (hold_reg.op == dptl_pkg::OP_INSERT)
                begin
                    if (hold_reg.last)
                    begin
                        if (ram_rdata.bound)
                        begin
                            err_next = dptl_pkg::STAT_BOUND;
                        end
                        else
                        begin
                            ram_we          = 1'b1;
                            ram_wdata.bound = 1'b1;
                            ram_wdata.dom   = hold_reg.dom;
                        end
                    end
                    else if (ram_rdata.child == '0)
                    begin
                        if (free_reg >= dptl_pkg::FREE_W'(dptl_pkg::NODE_COUNT))
                        begin
                            err_next = dptl_pkg::STAT_FULL;
                        end
                        else
                        begin
                            ram_we          = 1'b1;
                            ram_wdata.child = free_reg[dptl_pkg::NODE_W-1:0];
                            cur_next        = free_reg[dptl_pkg::NODE_W-1:0];
                            free_next       = free_reg + 1'b1;
                            pos_next        = pos_reg + 1'b1;
                        end
                    end
                    else
                    begin
                        cur_next = ram_rdata.child;
                        pos_next = pos_reg + 1'b1;
                    end
                end
                else
                begin
                    if (ram_rdata.bound)
                    begin
                        bdom_next = ram_rdata.dom;
                        blen_next = pos_reg + 1'b1;
                    end
                    if (ram_rdata.child == '0)
                    begin
                        ended_next = 1'b1;
                    end
                    else
                    begin
                        cur_next = ram_rdata.child;
                    end
                    pos_next = pos_reg + 1'b1;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        res_dom = '0;
        res_len = '0;
        if (err_next != dptl_pkg::ERR_NONE)
        begin
            res_status = err_next;
        end
        else if (done_op == dptl_pkg::OP_INSERT)
        begin
            res_status = dptl_pkg::STAT_INSERTED;
        end
        else if (blen_next != '0)
        begin
            res_status = dptl_pkg::STAT_MATCH;
            res_dom    = bdom_next;
            res_len    = blen_next;
        end
        else
        begin
            res_status = dptl_pkg::STAT_NOMATCH;
        end

        if (res_load)
        begin
            cur_next   = '0;
            pos_next   = '0;
            bdom_next  = '0;
            blen_next  = '0;
            ended_next = 1'b0;
            err_next   = dptl_pkg::ERR_NONE;
        end

        res_valid_next = res_load ? 1'b1 : (res_stall ? res_valid_reg : 1'b0);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            clr_reg       <= '0;
            cur_reg       <= '0;
            pos_reg       <= '0;
            bdom_reg      <= '0;
            blen_reg      <= '0;
            ended_reg     <= 1'b0;
            err_reg       <= dptl_pkg::ERR_NONE;
            free_reg      <= dptl_pkg::FREE_W'(1);
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_reg       <= clr_next;
            cur_reg       <= cur_next;
            pos_reg       <= pos_next;
            bdom_reg      <= bdom_next;
            blen_reg      <= blen_next;
            ended_reg     <= ended_next;
            err_reg       <= err_next;
            free_reg      <= free_next;
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        hold_reg <= hold_next;
        if (res_load)
        begin
            status_reg <= res_status;
            fdom_reg   <= res_dom;
            mlen_reg   <= res_len;
        end
    end

    assign res_valid    = res_valid_reg;
    assign status       = status_reg;
    assign found_domain = 16'(fdom_reg);
    assign match_length = 6'(mlen_reg);

    `DPTL_ASSERT(a_free_range, 1'b1, (free_reg != '0) && (free_reg <= dptl_pkg::FREE_W'(dptl_pkg::NODE_COUNT)), "node pool count out of range")
    `DPTL_ASSERT(a_node_alloc, 1'b1, dptl_pkg::FREE_W'(cur_reg) < free_reg, "walk points at unallocated node")
    `DPTL_ASSERT(a_no_pop_clear, state_reg == ST_CLEAR, !q_pop, "request taken during clear pass")
    `DPTL_ASSERT_NXT(a_exec_once, state_reg == ST_EXEC, state_reg == ST_IDLE, "exec step not single cycle")
    `DPTL_ASSERT(a_res_slot, res_load, !res_valid_reg || !res_stall, "result overwrites pending result")

endmodule

// File: rtl/digit_prefix_trie_lookup_core.sv
// Top level of the digit prefix trie lookup core: front end, request queue, walk engine.
// Depends on dptl_pkg, dptl_front, dptl_queue and dptl_back.
`timescale 1ns / 1ps

// Digit prefix trie with longest-prefix lookup and prefix insert, one character per
// request; a result comes out on the request with last_symbol set. After reset the
// 16384-entry node store is cleared one slot per cycle and sym_stall stays high
// meanwhile; configuration writes are taken at any time. A request that reads the
// node store goes through a store read, then a check and update step, since the
// next character needs the child node just read; a request settled without the store
// (pending error, ended lookup walk, invalid character, too long) needs no store read.
// A 2-entry request queue separates intake from the walk engine. The result register
// lets requests that produce no result proceed while a result waits on res_stall; a
// request with last_symbol set waits until that register frees.
module digit_prefix_trie_lookup_core (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [63:0] cfg_data,
    input  logic        sym_valid,
    output logic        sym_stall,
    input  logic        operation,
    input  logic [7:0]  symbol,
    input  logic        last_symbol,
    input  logic [5:0]  prefix_length,
    input  logic [15:0] domain_id,
    output logic        res_valid,
    input  logic        res_stall,
    output logic [2:0]  status,
    output logic [15:0] found_domain,
    output logic [5:0]  match_length
);

    logic            q_full;
    logic            q_push;
    logic            q_pop;
    logic            q_valid;
    logic            clearing;
    dptl_pkg::item_t push_item;
    dptl_pkg::item_t q_item;

    dptl_front u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .sym_valid     (sym_valid),
        .sym_stall     (sym_stall),
        .operation     (operation),
        .symbol        (symbol),
        .last_symbol   (last_symbol),
        .prefix_length (prefix_length),
        .domain_id     (domain_id),
        .q_full        (q_full),
        .clearing      (clearing),
        .q_push        (q_push),
        .q_item        (push_item)
    );

    dptl_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_item (push_item),
        .full      (q_full),
        .pop       (q_pop),
        .q_valid   (q_valid),
        .q_item    (q_item)
    );

    dptl_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .q_valid      (q_valid),
        .q_item       (q_item),
        .q_pop        (q_pop),
        .clearing     (clearing),
        .res_valid    (res_valid),
        .res_stall    (res_stall),
        .status       (status),
        .found_domain (found_domain),
        .match_length (match_length)
    );

endmodule
